FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. They are empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge, held off while reset is active.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, including during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg)

`define ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

FILE: hw/rtl/atcrm_pkg.sv
package atcrm_pkg;

    // Kind of an input request, carried in s_tuser.
    localparam logic MODE_POLL = 1'b0;
    localparam logic MODE_BYTE = 1'b1;

    // Status codes reported on poll results.
    localparam logic [1:0] STATUS_WAITING = 2'd0;
    localparam logic [1:0] STATUS_OK      = 2'd1;
    localparam logic [1:0] STATUS_ERROR   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [1:0] REG_RETRY_COUNT    = 2'd2;
    localparam logic [1:0] REG_WAIT_UNITS     = 2'd3;

    // Reset values of the configuration registers ("OK", two bytes, three tries).
    localparam logic [63:0] RESET_PATTERN_BYTES  = 64'd19279;
    localparam logic [3:0]  RESET_PATTERN_LENGTH = 4'd2;
    localparam logic [7:0]  RESET_RETRY_COUNT    = 8'd3;
    localparam logic [7:0]  RESET_WAIT_UNITS     = 8'd10;

    // Largest timeout value: ten polls times the largest wait unit count.
    localparam logic [11:0] TIMEOUT_MAX = 12'd2550;

    // Transaction phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SEND = 3'b010,
        PH_WAIT = 3'b100
    } phase_t;

endpackage

FILE: hw/rtl/at_command_retry_response_matcher.sv
// Command/response engine for a modem link.
// Input stream: s_tuser carries the request kind (0 = poll tick, 1 = received
// byte) and s_tdata carries the received byte. Every accepted request yields
// exactly one result on the output stream: m_tdata holds status, send_command
// and pattern_found. A poll steps the transaction (start, send with timeout,
// report OK or error, resend on timeout); a byte feeds the response matcher.
// m_tvalid rises in the cycle after acceptance, and one request can be
// accepted in every cycle: the next state and the result are computed by one
// level of compare and counter logic and loaded into the state and output
// registers together. s_tready drops only while a result is held in the output
// register and m_tready is low, so a stalled receiver stops the input after
// one pending result and nothing is lost. Synchronous reset puts the engine
// idle with all counters at zero and restores the configuration defaults
// (pattern "OK", length 2, three tries, ten wait units). The user is to write
// configuration through cfg_we/cfg_index/cfg_wdata while the stream is idle; not enforced.
`include "assert_macros.svh"

module at_command_retry_response_matcher #(
    parameter int PATTERN_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // Input requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] mode
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] status, [2] send_command,
                                   // [3] pattern_found, [7:4] zero
);

    localparam int LEN_CAP = (PATTERN_BYTES < 8) ? PATTERN_BYTES : 8;

    // Configuration registers.
    logic [63:0] pattern_bytes_reg;
    logic [3:0]  pattern_length_reg;
    logic [7:0]  retry_count_reg;
    logic [7:0]  wait_units_reg;

    // Transaction and matcher state.
    atcrm_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  retries_left_reg, retries_left_next;
    logic [11:0] timeout_count_reg, timeout_count_next;
    logic        awaiting_reply_reg, awaiting_reply_next;
    logic        match_active_reg, match_active_next;
    logic [3:0]  match_remaining_reg, match_remaining_next;

    // Output register.
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;

    logic        accept;
    logic [1:0]  status_next;
    logic        send_next;
    logic        found_next;
    logic [3:0]  eff_len;
    logic [11:0] timeout_dec;
    logic [11:0] timeout_load;
    logic [3:0]  byte_index;
    logic [7:0]  expected_byte;
    logic [7:0]  first_byte;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bytes_reg  <= atcrm_pkg::RESET_PATTERN_BYTES;
            pattern_length_reg <= atcrm_pkg::RESET_PATTERN_LENGTH;
            retry_count_reg    <= atcrm_pkg::RESET_RETRY_COUNT;
            wait_units_reg     <= atcrm_pkg::RESET_WAIT_UNITS;
        end else if (cfg_we) begin
            case (cfg_index)
                atcrm_pkg::REG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_wdata;
                atcrm_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[3:0];
                atcrm_pkg::REG_RETRY_COUNT:    retry_count_reg    <= cfg_wdata[7:0];
                atcrm_pkg::REG_WAIT_UNITS:     wait_units_reg     <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Effective pattern length: zero counts as one, capped at the storage size.
    always_comb begin
        eff_len = pattern_length_reg;
        if (eff_len == 4'd0) begin
            eff_len = 4'd1;
        end
        if (eff_len > 4'(LEN_CAP)) begin
            eff_len = 4'(LEN_CAP);
        end
    end

    // Timeout helpers: count down by one, and ten times the wait units.
    assign timeout_dec  = (timeout_count_reg != 12'd0) ? timeout_count_reg - 12'd1
                                                       : timeout_count_reg;
    assign timeout_load = {1'b0, wait_units_reg, 3'b000} + {3'b000, wait_units_reg, 1'b0};

    // Pattern bytes the matcher compares against.
    assign byte_index    = eff_len - match_remaining_reg;
    assign expected_byte = pattern_bytes_reg[byte_index[2:0]*8 +: 8];
    assign first_byte    = pattern_bytes_reg[7:0];

    // Next state and result for the request at the input.
    always_comb begin
        phase_next           = phase_reg;
        retries_left_next    = retries_left_reg;
        timeout_count_next   = timeout_count_reg;
        awaiting_reply_next  = awaiting_reply_reg;
        match_active_next    = match_active_reg;
        match_remaining_next = match_remaining_reg;
        status_next          = atcrm_pkg::STATUS_WAITING;
        send_next            = 1'b0;
        found_next           = 1'b0;

        if (s_tuser == atcrm_pkg::MODE_POLL) begin
            timeout_count_next = timeout_dec;
            case (phase_reg)
                atcrm_pkg::PH_IDLE: begin
                    retries_left_next    = retry_count_reg;
                    awaiting_reply_next  = 1'b1;
                    match_active_next    = 1'b0;
                    match_remaining_next = eff_len;
                    phase_next           = atcrm_pkg::PH_SEND;
                end
                atcrm_pkg::PH_SEND: begin
                    if (retries_left_reg != 8'd0) begin
                        timeout_count_next = timeout_load;
                        send_next          = 1'b1;
                        retries_left_next  = retries_left_reg - 8'd1;
                        phase_next         = atcrm_pkg::PH_WAIT;
                    end else begin
                        phase_next          = atcrm_pkg::PH_IDLE;
                        awaiting_reply_next = 1'b0;
                        status_next         = atcrm_pkg::STATUS_ERROR;
                    end
                end
                atcrm_pkg::PH_WAIT: begin
                    if (!awaiting_reply_reg) begin
                        phase_next  = atcrm_pkg::PH_IDLE;
                        status_next = atcrm_pkg::STATUS_OK;
                    end else if (timeout_dec == 12'd0) begin
                        phase_next = atcrm_pkg::PH_SEND;
                    end
                end
                default: begin
                    phase_next  = atcrm_pkg::PH_IDLE;
                    status_next = atcrm_pkg::STATUS_ERROR;
                end
            endcase
        end else if (awaiting_reply_reg) begin
            // Naive matcher: a mismatch restarts without rechecking this byte.
            if (!match_active_reg) begin
                if (s_tdata == first_byte) begin
                    match_active_next    = 1'b1;
                    match_remaining_next = eff_len - 4'd1;
                    if (eff_len == 4'd1) begin
                        match_active_next   = 1'b0;
                        awaiting_reply_next = 1'b0;
                        found_next          = 1'b1;
                    end
                end
            end else if (match_remaining_reg == 4'd0 || match_remaining_reg >= eff_len) begin
                match_active_next = 1'b0;
            end else if (s_tdata != expected_byte) begin
                match_active_next = 1'b0;
            end else begin
                match_remaining_next = match_remaining_reg - 4'd1;
                if (match_remaining_reg == 4'd1) begin
                    match_active_next   = 1'b0;
                    awaiting_reply_next = 1'b0;
                    found_next          = 1'b1;
                end
            end
        end
    end

    // State update on each accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= atcrm_pkg::PH_IDLE;
            retries_left_reg    <= 8'd0;
            timeout_count_reg   <= 12'd0;
            awaiting_reply_reg  <= 1'b0;
            match_active_reg    <= 1'b0;
            match_remaining_reg <= 4'd0;
        end else if (accept) begin
            phase_reg           <= phase_next;
            retries_left_reg    <= retries_left_next;
            timeout_count_reg   <= timeout_count_next;
            awaiting_reply_reg  <= awaiting_reply_next;
            match_active_reg    <= match_active_next;
            match_remaining_reg <= match_remaining_next;
        end
    end

    // Output register: loads on accept, clears once the result is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {4'b0000, found_next, send_next, status_next};
        end
    end

    // A send request always leaves the engine waiting for the reply.
    `ASSERT_CLK_RST(a_send_enters_wait, aclk, aresetn, (accept && send_next) |=> (phase_reg == atcrm_pkg::PH_WAIT), "send without entering wait phase")

    // A completed pattern ends the wait for a reply.
    `ASSERT_CLK_RST(a_found_clears_wait, aclk, aresetn, (accept && found_next) |=> !awaiting_reply_reg, "pattern found but reply still awaited")

    // The timeout count never exceeds ten polls times the largest wait unit count.
    `ASSERT_CLK_RST(a_timeout_range, aclk, aresetn, timeout_count_reg <= atcrm_pkg::TIMEOUT_MAX, "timeout count out of range")

    // Reset leaves no result pending.
    `ASSERT_CLK(a_reset_clears_valid, aclk, !aresetn |=> !m_tvalid_reg, "result valid right after reset")

endmodule

FILE: test/atcrm_checker.sv
// Watches the request, result and configuration ports of the modem command
// engine, keeps its own copy of the engine state and checks every result.
module atcrm_checker #(
    parameter int PATTERN_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [1:0] status, [2] send_command,
                                   // [3] pattern_found, [7:4] zero
    output int          fail_count,
    output int          results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_CAP       = (PATTERN_BYTES < 8) ? PATTERN_BYTES : 8;
    localparam int TIMEOUT_SCALE = 10;

    typedef struct packed {
        logic [1:0] status;
        logic       send_command;
        logic       pattern_found;
    } reply_t;

    // Shadow copy of the configuration registers.
    logic [63:0] pattern_cfg;
    logic [3:0]  length_cfg;
    logic [7:0]  tries_cfg;
    logic [7:0]  units_cfg;

    // Shadow copy of the transaction and matcher state.
    atcrm_pkg::phase_t txn_phase;
    logic [7:0]  tries_left;
    logic [11:0] timeout_left;
    logic        awaiting_reply;
    logic        match_active;
    logic [3:0]  match_left;

    reply_t reply_q[$];
    int     fails = 0;
    int     due   = 0;

    assign fail_count  = fails;
    assign results_due = due;

    // Pattern length as the engine uses it: zero means one, and it is capped.
    function automatic logic [3:0] match_length();
        int len;
        len = int'(length_cfg);
        if (len == 0) len = 1;
        if (len > LEN_CAP) len = LEN_CAP;
        return 4'(len);
    endfunction

    function automatic logic [7:0] pattern_byte(input logic [3:0] idx);
        int sh;
        sh = (int'(idx) % 8) * 8;
        return pattern_cfg[sh +: 8];
    endfunction

    // Applies one request to the shadow state and returns the result it causes.
    function automatic reply_t advance(input logic mode, input logic [7:0] rx_byte);
        reply_t     r;
        logic [3:0] len;
        r   = '0;
        len = match_length();
        if (mode == atcrm_pkg::MODE_POLL) begin
            if (timeout_left != 0) timeout_left--;
            case (txn_phase)
                atcrm_pkg::PH_IDLE: begin
                    tries_left     = tries_cfg;
                    awaiting_reply = 1'b1;
                    match_active   = 1'b0;
                    match_left     = len;
                    txn_phase      = atcrm_pkg::PH_SEND;
                end
                atcrm_pkg::PH_SEND: begin
                    if (tries_left != 0) begin
                        timeout_left   = 12'(TIMEOUT_SCALE * int'(units_cfg));
                        r.send_command = 1'b1;
                        tries_left--;
                        txn_phase      = atcrm_pkg::PH_WAIT;
                    end else begin
                        txn_phase      = atcrm_pkg::PH_IDLE;
                        awaiting_reply = 1'b0;
                        r.status       = atcrm_pkg::STATUS_ERROR;
                    end
                end
                atcrm_pkg::PH_WAIT: begin
                    if (!awaiting_reply) begin
                        txn_phase = atcrm_pkg::PH_IDLE;
                        r.status  = atcrm_pkg::STATUS_OK;
                    end else if (timeout_left == 0) begin
                        txn_phase = atcrm_pkg::PH_SEND;
                    end
                end
                default: begin
                    txn_phase = atcrm_pkg::PH_IDLE;
                    r.status  = atcrm_pkg::STATUS_ERROR;
                end
            endcase
        end else if (awaiting_reply) begin
            // Naive matcher: a mismatch restarts without rechecking the byte.
            if (!match_active) begin
                if (rx_byte == pattern_byte(4'd0)) begin
                    match_active = 1'b1;
                    match_left   = len - 4'd1;
                    if (len == 4'd1) begin
                        match_active    = 1'b0;
                        awaiting_reply  = 1'b0;
                        r.pattern_found = 1'b1;
                    end
                end
            end else if (match_left == 0 || match_left >= len) begin
                // The length shrank under a running match.
                match_active = 1'b0;
            end else if (rx_byte != pattern_byte(len - match_left)) begin
                match_active = 1'b0;
            end else begin
                match_left--;
                if (match_left == 0) begin
                    match_active    = 1'b0;
                    awaiting_reply  = 1'b0;
                    r.pattern_found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        reply_t want;
        if (!aresetn) begin
            pattern_cfg    = atcrm_pkg::RESET_PATTERN_BYTES;
            length_cfg     = atcrm_pkg::RESET_PATTERN_LENGTH;
            tries_cfg      = atcrm_pkg::RESET_RETRY_COUNT;
            units_cfg      = atcrm_pkg::RESET_WAIT_UNITS;
            txn_phase      = atcrm_pkg::PH_IDLE;
            tries_left     = '0;
            timeout_left   = '0;
            awaiting_reply = 1'b0;
            match_active   = 1'b0;
            match_left     = '0;
            reply_q.delete();
        end else begin
            // Register writes are to happen only while no request is in flight; not enforced here.
            if (cfg_we) begin
                case (cfg_index)
                    atcrm_pkg::REG_PATTERN_BYTES:  pattern_cfg = cfg_wdata;
                    atcrm_pkg::REG_PATTERN_LENGTH: length_cfg  = cfg_wdata[3:0];
                    atcrm_pkg::REG_RETRY_COUNT:    tries_cfg   = cfg_wdata[7:0];
                    atcrm_pkg::REG_WAIT_UNITS:     units_cfg   = cfg_wdata[7:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) reply_q.push_back(advance(s_tuser, s_tdata));

            // Each accepted result is matched against the oldest expectation.
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    $error("unexpected result: m_tdata=%h with no request pending", m_tdata);
                    fails++;
                end else begin
                    want = reply_q.pop_front();
                    compare_field("status", 8'(want.status), 8'(m_tdata[1:0]));
                    compare_field("send_command", 8'(want.send_command), 8'(m_tdata[2]));
                    compare_field("pattern_found", 8'(want.pattern_found), 8'(m_tdata[3]));
                    compare_field("reserved", 8'd0, 8'(m_tdata[7:4]));
                end
            end
        end
        due <= reply_q.size();
    end

endmodule

FILE: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PATTERN_BYTES = 8;
    localparam int LEN_CAP       = (PATTERN_BYTES < 8) ? PATTERN_BYTES : 8;
    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int CALM_ITEMS    = 60;
    localparam int SETTING_SPAN  = 75;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = atcrm_pkg::REG_PATTERN_BYTES;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = atcrm_pkg::MODE_POLL;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;

    int fail_total;
    int results_due;

    // Stimulus bookkeeping.
    logic        calm = 1'b0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int          sent_items = 0;
    int          poll_count = 0;
    int          byte_count = 0;
    int          setting_count = 0;
    logic [63:0] cur_pat = atcrm_pkg::RESET_PATTERN_BYTES;
    int          cur_len = int'(atcrm_pkg::RESET_PATTERN_LENGTH);

    at_command_retry_response_matcher #(
        .PATTERN_BYTES(PATTERN_BYTES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    atcrm_checker #(
        .PATTERN_BYTES(PATTERN_BYTES)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_total),
        .results_due (results_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: random stall bursts, none once the run has gone calm.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 7);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles.", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] pat_byte(input int idx);
        return cur_pat[8 * idx +: 8];
    endfunction

    // Half the noise bytes come from the pattern so that partial matches occur.
    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1) == 0) return pat_byte($urandom_range(0, 7));
        return 8'($urandom);
    endfunction

    // Presents one request, after a random gap unless the run is calm.
    task automatic send_req(input logic mode, input logic [7:0] data);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
        if (mode == atcrm_pkg::MODE_POLL) poll_count++;
        else byte_count++;
    endtask

    task automatic poll();
        send_req(atcrm_pkg::MODE_POLL, 8'($urandom));
    endtask

    // Holds the sender until every outstanding result has been returned.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Writes all four registers; unused upper bits carry random junk.
    task automatic load_settings(input logic [63:0] pat, input logic [3:0] len,
                                 input logic [7:0] tries, input logic [7:0] units);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(atcrm_pkg::REG_PATTERN_BYTES, pat);
        write_reg(atcrm_pkg::REG_PATTERN_LENGTH, {junk[63:4], len});
        write_reg(atcrm_pkg::REG_RETRY_COUNT, {junk[63:8], tries});
        write_reg(atcrm_pkg::REG_WAIT_UNITS, {junk[63:8], units});
        cfg_we  <= 1'b0;
        cur_pat = pat;
        cur_len = (len == 0) ? 1 : ((int'(len) > LEN_CAP) ? LEN_CAP : int'(len));
        setting_count++;
    endtask

    // A well-formed exchange: start, send, some noise, usually the reply.
    task automatic run_transaction();
        int bad_at;
        poll();
        poll();
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 1) == 0) poll();
            else send_req(atcrm_pkg::MODE_BYTE, noise_byte());
        end
        if ($urandom_range(0, 3) != 0) begin
            bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cur_len - 1) : -1;
            for (int i = 0; i < cur_len; i++)
                send_req(atcrm_pkg::MODE_BYTE, (i == bad_at) ? 8'($urandom) : pat_byte(i));
        end
        repeat ($urandom_range(1, 3)) poll();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: byte while idle, a reply with a broken first try.
        send_req(atcrm_pkg::MODE_BYTE, pat_byte(0));
        poll();
        poll();
        send_req(atcrm_pkg::MODE_BYTE, pat_byte(0));
        send_req(atcrm_pkg::MODE_BYTE, 8'h58);
        send_req(atcrm_pkg::MODE_BYTE, pat_byte(1));
        send_req(atcrm_pkg::MODE_BYTE, pat_byte(0));
        send_req(atcrm_pkg::MODE_BYTE, pat_byte(1));
        poll();
        send_req(atcrm_pkg::MODE_BYTE, 8'hFF);
        send_req(atcrm_pkg::MODE_BYTE, 8'h00);

        // Zero retries: the first send poll reports an error.
        drain_results();
        load_settings(64'h8877_6655_4433_2211, 4'd4, 8'd0, 8'd0);
        poll();
        poll();

        // Start a match, then shrink the length under it.
        drain_results();
        load_settings(64'h8877_6655_4433_2211, 4'd4, 8'd2, 8'd0);
        poll();
        poll();
        send_req(atcrm_pkg::MODE_BYTE, pat_byte(0));
        send_req(atcrm_pkg::MODE_BYTE, pat_byte(1));
        drain_results();
        load_settings(64'h8877_6655_4433_2211, 4'd2, 8'd2, 8'd0);
        send_req(atcrm_pkg::MODE_BYTE, pat_byte(2));
        // Immediate timeouts until the retries run out.
        poll();
        poll();
        poll();
        poll();

        // Length zero behaves as one byte; longest timeout and retry count.
        drain_results();
        load_settings('1, 4'd0, 8'd255, 8'd255);
        poll();
        poll();
        send_req(atcrm_pkg::MODE_BYTE, 8'hFF);
        poll();

        // Random part, one register setting per span.
        for (int k = 0; k < RANDOM_ITEMS / SETTING_SPAN; k++) begin
            drain_results();
            case (k)
                0:       load_settings({$urandom, $urandom}, 4'd2, 8'd3, 8'd1);
                1:       load_settings({$urandom, $urandom}, 4'd8, 8'd255, 8'd0);
                2:       load_settings('0, 4'd1, 8'd1, 8'd2);
                3:       load_settings('1, 4'd15, 8'd0, 8'd255);
                4:       load_settings({$urandom, $urandom}, 4'd0, 8'd2, 8'd1);
                default: load_settings({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                                       8'($urandom_range(0, 4)), 8'($urandom_range(0, 3)));
            endcase
            while (sent_items < poll_count + byte_count + 1 &&
                   sent_items < 30 + (k + 1) * SETTING_SPAN) begin
                if (sent_items >= 30 + RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
                if ($urandom_range(0, 9) < 7) run_transaction();
                else send_req(1'($urandom), noise_byte());
            end
        end

        drain_results();
        repeat (4) @(posedge aclk);
        $display("Covered %0d polls and %0d received bytes under %0d register settings.",
                 poll_count, byte_count, setting_count + 1);
        if (fail_total == 0 && results_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
